// ===== rtl/core/eff2d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eff2d_pkg
// Types, constants and fixed-point helpers for the 2D Euler face flux core.
// ----------------------------------------------------------------------------
package eff2d_pkg;

    localparam int NUM_CONSERVED = 4;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [32:0] Q_ONE   = 33'sd65536;

    // config port
    localparam int          PADDR_W     = 3;
    localparam logic        REG_GAMMA   = 1'b0;
    localparam logic [17:0] GAMMA_RESET = 18'd91750;

    // divider and square-root step counts; core latency in clock edges after the T0 input register
    localparam int DIV_STEPS = 32;
    localparam int SQRT_STEPS = 32;
    localparam int PIPE_LAT  = 74;

    // shift line depths
    localparam int SD_P   = 35;
    localparam int SD_RHO = 36;
    localparam int SD_KE  = 31;
    localparam int SD_OPS = 67;
    localparam int CD_OPS = 36;
    localparam int CD_RES = 33;
    localparam int TD_FACE = 34;

    typedef struct packed {
        logic        [30:0] rho_left;
        logic signed [31:0] u_left;
        logic signed [31:0] v_left;
        logic        [30:0] p_left;
        logic        [30:0] rho_right;
        logic signed [31:0] u_right;
        logic signed [31:0] v_right;
        logic        [30:0] p_right;
        logic signed [31:0] face_x;
        logic signed [31:0] face_y;
        logic               last_face;
    } face_item_t;

    typedef struct packed {
        logic signed [31:0] avg_flux_mass;
        logic signed [31:0] avg_flux_xmom;
        logic signed [31:0] avg_flux_ymom;
        logic signed [31:0] avg_flux_energy;
        logic signed [31:0] flux_diff_mass;
        logic signed [31:0] flux_diff_xmom;
        logic signed [31:0] flux_diff_ymom;
        logic signed [31:0] flux_diff_energy;
        logic signed [31:0] cons_diff_mass;
        logic signed [31:0] cons_diff_xmom;
        logic signed [31:0] cons_diff_ymom;
        logic signed [31:0] cons_diff_energy;
    } face_result_t;

    typedef struct packed {
        logic signed [31:0] mass;
        logic signed [31:0] xmom;
        logic signed [31:0] ymom;
        logic signed [31:0] energy;
    } cons4_t;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] x);
        if (x[32] != x[31])
        begin
            return x[32] ? S32_MIN : S32_MAX;
        end
        return x[31:0];
    endfunction

    function automatic logic signed [31:0] sat48(input logic signed [47:0] x);
        if ((x[47:31] == '0) || (x[47:31] == '1))
        begin
            return x[31:0];
        end
        return x[47] ? S32_MIN : S32_MAX;
    endfunction

    function automatic logic signed [31:0] qadd(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return sat33({a[31], a} + {b[31], b});
    endfunction

    function automatic logic signed [31:0] qsub(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        return sat33({a[31], a} - {b[31], b});
    endfunction

    // floor((a+b)/2) never leaves the 32-bit range
    function automatic logic signed [31:0] qavg(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic [32:0] s;
        s = {a[31], a} + {b[31], b};
        return s[32:1];
    endfunction

    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] prod;
        prod = 64'(a) * 64'(b);
        return sat48(prod[63:16]);
    endfunction

endpackage

// ===== rtl/core/euler_face_flux_2d_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_face_flux_2d_core
// 2D Euler face flux: central flux of the averaged state, normal flux
// difference and conserved differences for one face per clock.
// ----------------------------------------------------------------------------
//  channel   handshake                      payload
//  input     start (busy held low)          item   (face_item_t)
//  result    done, one-cycle strobe         result (face_result_t)
//  config    APB psel/penable/pwrite/pready paddr, pwdata, prdata
//
//  One face per clock; done strobes when the taken transfer reaches the end of the valid line.
//  Latency is set by the enthalpy path: two chained dividers.
//  rst_n clears the valid line and gamma_reg (1.4); data regs are not reset.
//  No stalls: the pipeline advances every cycle.
// ----------------------------------------------------------------------------
module euler_face_flux_2d_core
    import eff2d_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  face_item_t         item,
    output logic               done,
    output face_result_t       result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [17:0]        gamma_reg;
    logic [PIPE_LAT:0]  valid_reg;
    face_item_t         item_reg;
    logic signed [32:0] gm1;
    logic signed [63:0] fxx_reg, fyy_reg;
    logic [63:0]        sq_reg;
    logic [31:0]        ds;
    logic signed [31:0] fx_dly_reg [TD_FACE];
    logic signed [31:0] fy_dly_reg [TD_FACE];
    logic signed [31:0] nx, ny, nx69_reg, ny69_reg, nx70_reg, ny70_reg;
    logic signed [31:0] mu_l, mv_l, e_l, mu_r, mv_r, e_r;
    cons4_t             flux_l, flux_r, avg, cdf;
    face_result_t       result_reg;
    logic               cfg_wr;

    assign busy   = 1'b0;
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;
    assign prdata = (paddr[PADDR_W-1] == REG_GAMMA) ? {14'b0, gamma_reg} : '0;
    assign gm1    = $signed({15'b0, gamma_reg}) - Q_ONE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg <= GAMMA_RESET;
            valid_reg <= '0;
        end
        else
        begin
            if (cfg_wr && (paddr[PADDR_W-1] == REG_GAMMA))
            begin
                gamma_reg <= pwdata[17:0];
            end
            valid_reg <= {valid_reg[PIPE_LAT-1:0], start & ~busy};
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            item_reg <= item;
        end
        fxx_reg  <= 64'(item_reg.face_x) * 64'(item_reg.face_x);
        fyy_reg  <= 64'(item_reg.face_y) * 64'(item_reg.face_y);
        sq_reg   <= fxx_reg + fyy_reg;
        nx69_reg <= nx;
        ny69_reg <= ny;
        nx70_reg <= nx69_reg;
        ny70_reg <= ny69_reg;
        fx_dly_reg[0] <= item_reg.face_x;
        fy_dly_reg[0] <= item_reg.face_y;
        for (int k = 1; k < TD_FACE; k++)
        begin
            fx_dly_reg[k] <= fx_dly_reg[k-1];
            fy_dly_reg[k] <= fy_dly_reg[k-1];
        end
    end

    eff2d_sqrt u_sqrt (
        .clk  (clk),
        .sq   (sq_reg),
        .root (ds)
    );

    eff2d_div u_nxdiv (
        .clk (clk),
        .num (fx_dly_reg[TD_FACE-1]),
        .den ({1'b0, ds}),
        .quo (nx)
    );

    eff2d_div u_nydiv (
        .clk (clk),
        .num (fy_dly_reg[TD_FACE-1]),
        .den ({1'b0, ds}),
        .quo (ny)
    );

    eff2d_side u_left (
        .clk  (clk),
        .rho  (item_reg.rho_left),
        .u    (item_reg.u_left),
        .v    (item_reg.v_left),
        .p    (item_reg.p_left),
        .gm1  (gm1),
        .nx   (nx70_reg),
        .ny   (ny70_reg),
        .mu   (mu_l),
        .mv   (mv_l),
        .e    (e_l),
        .flux (flux_l)
    );

    eff2d_side u_right (
        .clk  (clk),
        .rho  (item_reg.rho_right),
        .u    (item_reg.u_right),
        .v    (item_reg.v_right),
        .p    (item_reg.p_right),
        .gm1  (gm1),
        .nx   (nx70_reg),
        .ny   (ny70_reg),
        .mu   (mu_r),
        .mv   (mv_r),
        .e    (e_r),
        .flux (flux_r)
    );

    eff2d_central u_central (
        .clk   (clk),
        .rho_l (item_reg.rho_left),
        .rho_r (item_reg.rho_right),
        .p_l   (item_reg.p_left),
        .p_r   (item_reg.p_right),
        .fx    (item_reg.face_x),
        .fy    (item_reg.face_y),
        .mu_l  (mu_l),
        .mu_r  (mu_r),
        .mv_l  (mv_l),
        .mv_r  (mv_r),
        .e_l   (e_l),
        .e_r   (e_r),
        .avg   (avg),
        .cdf   (cdf)
    );

    always_ff @(posedge clk)
    begin
        result_reg.avg_flux_mass    <= avg.mass;
        result_reg.avg_flux_xmom    <= avg.xmom;
        result_reg.avg_flux_ymom    <= avg.ymom;
        result_reg.avg_flux_energy  <= avg.energy;
        result_reg.flux_diff_mass   <= qsub(flux_r.mass, flux_l.mass);
        result_reg.flux_diff_xmom   <= qsub(flux_r.xmom, flux_l.xmom);
        result_reg.flux_diff_ymom   <= qsub(flux_r.ymom, flux_l.ymom);
        result_reg.flux_diff_energy <= qsub(flux_r.energy, flux_l.energy);
        result_reg.cons_diff_mass   <= cdf.mass;
        result_reg.cons_diff_xmom   <= cdf.xmom;
        result_reg.cons_diff_ymom   <= cdf.ymom;
        result_reg.cons_diff_energy <= cdf.energy;
    end

    assign done   = valid_reg[PIPE_LAT];
    assign result = result_reg;

endmodule

// ===== rtl/core/eff2d_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eff2d_div
// Pipelined Q16.16 divider, (num * 2^16) / den truncated toward zero and
// saturated; one quotient bit per stage.
// ----------------------------------------------------------------------------
module eff2d_div
    import eff2d_pkg::*;
(
    input  logic               clk,
    input  logic signed [31:0] num,
    input  logic signed [32:0] den,
    output logic signed [31:0] quo
);

    typedef struct packed {
        logic [47:0] rem;
        logic [31:0] qbits;
        logic [31:0] dmag;
        logic        neg;
        logic        nz;
        logic        over;
    } div_stage_t;

    div_stage_t         st_reg  [DIV_STEPS+1];
    div_stage_t         st_next [DIV_STEPS+1];
    logic signed [31:0] quo_reg;
    logic signed [31:0] quo_next;

    function automatic div_stage_t div_step(input div_stage_t s, input int k);
        div_stage_t r;
        logic [63:0] sub;
        logic [63:0] trial;
        logic [63:0] diff;
        r     = s;
        sub   = {32'b0, s.dmag} << k;
        trial = {16'b0, s.rem};
        diff  = trial - sub;
        if (trial >= sub)
        begin
            r.rem      = diff[47:0];
            r.qbits[k] = 1'b1;
        end
        return r;
    endfunction

    always_comb
    begin
        logic [31:0] num_u;
        logic [31:0] nmag;
        logic [32:0] den_u;
        logic [32:0] dabs;
        num_u = num;
        nmag  = num[31] ? (~num_u + 32'd1) : num_u;
        den_u = den;
        dabs  = den[32] ? (~den_u + 33'd1) : den_u;
        st_next[0].rem   = {nmag, 16'b0};
        st_next[0].qbits = '0;
        st_next[0].dmag  = dabs[31:0];
        st_next[0].neg   = num[31] ^ den[32];
        st_next[0].nz    = (num != '0);
        st_next[0].over  = ({16'b0, nmag, 16'b0} >= {dabs[31:0], 32'b0});
        for (int i = 0; i < DIV_STEPS; i++)
        begin
            st_next[i+1] = div_step(st_reg[i], DIV_STEPS - 1 - i);
        end
    end

    always_comb
    begin
        div_stage_t f;
        f = st_reg[DIV_STEPS];
        if (!f.nz)
        begin
            quo_next = '0;
        end
        else if (f.over)
        begin
            quo_next = f.neg ? S32_MIN : S32_MAX;
        end
        else if (f.neg)
        begin
            quo_next = (f.qbits > 32'h8000_0000) ? S32_MIN : (~f.qbits + 32'd1);
        end
        else
        begin
            quo_next = f.qbits[31] ? S32_MAX : f.qbits;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg  <= st_next;
        quo_reg <= quo_next;
    end

    assign quo = quo_reg;

endmodule

// ===== rtl/core/eff2d_sqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eff2d_sqrt
// Pipelined integer square root of a 64-bit value, one root bit per stage.
// ----------------------------------------------------------------------------
module eff2d_sqrt
    import eff2d_pkg::*;
(
    input  logic        clk,
    input  logic [63:0] sq,
    output logic [31:0] root
);

    typedef struct packed {
        logic [63:0] x;
        logic [63:0] r;
    } sqrt_stage_t;

    sqrt_stage_t st_reg  [SQRT_STEPS];
    sqrt_stage_t st_next [SQRT_STEPS];

    function automatic sqrt_stage_t sqrt_step(input sqrt_stage_t s, input int j);
        sqrt_stage_t o;
        logic [63:0] b;
        logic [63:0] t;
        b = 64'd1 << (62 - 2 * j);
        t = s.r + b;
        if (s.x >= t)
        begin
            o.x = s.x - t;
            o.r = (s.r >> 1) + b;
        end
        else
        begin
            o.x = s.x;
            o.r = s.r >> 1;
        end
        return o;
    endfunction

    always_comb
    begin
        sqrt_stage_t s0;
        s0.x = sq;
        s0.r = '0;
        st_next[0] = sqrt_step(s0, 0);
        for (int j = 1; j < SQRT_STEPS; j++)
        begin
            st_next[j] = sqrt_step(st_reg[j-1], j);
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg <= st_next;
    end

    assign root = st_reg[SQRT_STEPS-1].r[31:0];

endmodule

// ===== rtl/core/eff2d_side.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eff2d_side
// One cell side: momenta, total energy, enthalpy and normal Euler flux.
// Inputs at T0, mu/mv at T1, e at T35, nx/ny expected at T70, flux at T73.
// ----------------------------------------------------------------------------
module eff2d_side
    import eff2d_pkg::*;
(
    input  logic               clk,
    input  logic        [30:0] rho,
    input  logic signed [31:0] u,
    input  logic signed [31:0] v,
    input  logic        [30:0] p,
    input  logic signed [32:0] gm1,
    input  logic signed [31:0] nx,
    input  logic signed [31:0] ny,
    output logic signed [31:0] mu,
    output logic signed [31:0] mv,
    output logic signed [31:0] e,
    output cons4_t             flux
);

    typedef struct packed {
        logic signed [31:0] mu;
        logic signed [31:0] mv;
        logic signed [31:0] a1;
        logic signed [31:0] a2;
        logic signed [31:0] muv;
    } flux_ops_t;

    logic signed [31:0] p_s;
    logic signed [31:0] uu_reg, vv_reg, mu_reg, mv_reg, u1_reg, v1_reg;
    logic signed [31:0] q_reg, muu_reg, mvv_reg, muv_reg, mu2_reg, mv2_reg;
    logic signed [31:0] ke_reg, e_reg, ep_reg;
    logic signed [31:0] p_dly_reg   [SD_P];
    logic        [30:0] rho_dly_reg [SD_RHO];
    logic signed [31:0] ke_dly_reg  [SD_KE];
    flux_ops_t          ops3_reg;
    flux_ops_t          ops_dly_reg [SD_OPS];
    flux_ops_t          ops70;
    logic signed [31:0] pq, h;
    logic signed [31:0] m0_reg, m1_reg, m2_reg, m3_reg, m4_reg, m5_reg;
    logic signed [31:0] muh_reg, mvh_reg, nx71_reg, ny71_reg;
    logic signed [31:0] f0_reg, f1_reg, f2_reg, m6_reg, m7_reg;
    cons4_t             flux_reg;

    assign p_s   = {1'b0, p};
    assign ops70 = ops_dly_reg[SD_OPS-1];

    eff2d_div u_pdiv (
        .clk (clk),
        .num (p_s),
        .den (gm1),
        .quo (pq)
    );

    eff2d_div u_hdiv (
        .clk (clk),
        .num (ep_reg),
        .den ({2'b00, rho_dly_reg[SD_RHO-1]}),
        .quo (h)
    );

    always_ff @(posedge clk)
    begin
        // T1
        uu_reg <= qmul(u, u);
        vv_reg <= qmul(v, v);
        mu_reg <= qmul({1'b0, rho}, u);
        mv_reg <= qmul({1'b0, rho}, v);
        u1_reg <= u;
        v1_reg <= v;
        // T2
        q_reg   <= qadd(uu_reg, vv_reg);
        muu_reg <= qmul(mu_reg, u1_reg);
        mvv_reg <= qmul(mv_reg, v1_reg);
        muv_reg <= qmul(mu_reg, v1_reg);
        mu2_reg <= mu_reg;
        mv2_reg <= mv_reg;
        // T3
        ke_reg       <= qmul({2'b00, rho_dly_reg[1][30:1]}, q_reg);
        ops3_reg.mu  <= mu2_reg;
        ops3_reg.mv  <= mv2_reg;
        ops3_reg.a1  <= qadd(muu_reg, p_dly_reg[1]);
        ops3_reg.a2  <= qadd(mvv_reg, p_dly_reg[1]);
        ops3_reg.muv <= muv_reg;
        // T35, T36
        e_reg  <= qadd(pq, ke_dly_reg[SD_KE-1]);
        ep_reg <= qadd(e_reg, p_dly_reg[SD_P-1]);
        // T71
        m0_reg   <= qmul(ops70.mu, nx);
        m1_reg   <= qmul(ops70.mv, ny);
        m2_reg   <= qmul(ops70.a1, nx);
        m3_reg   <= qmul(ops70.muv, ny);
        m4_reg   <= qmul(ops70.muv, nx);
        m5_reg   <= qmul(ops70.a2, ny);
        muh_reg  <= qmul(ops70.mu, h);
        mvh_reg  <= qmul(ops70.mv, h);
        nx71_reg <= nx;
        ny71_reg <= ny;
        // T72
        f0_reg <= qadd(m0_reg, m1_reg);
        f1_reg <= qadd(m2_reg, m3_reg);
        f2_reg <= qadd(m4_reg, m5_reg);
        m6_reg <= qmul(muh_reg, nx71_reg);
        m7_reg <= qmul(mvh_reg, ny71_reg);
        // T73
        flux_reg.mass   <= f0_reg;
        flux_reg.xmom   <= f1_reg;
        flux_reg.ymom   <= f2_reg;
        flux_reg.energy <= qadd(m6_reg, m7_reg);
    end

    always_ff @(posedge clk)
    begin
        p_dly_reg[0]   <= p_s;
        rho_dly_reg[0] <= rho;
        ke_dly_reg[0]  <= ke_reg;
        ops_dly_reg[0] <= ops3_reg;
        for (int k = 1; k < SD_P; k++)
        begin
            p_dly_reg[k] <= p_dly_reg[k-1];
        end
        for (int k = 1; k < SD_RHO; k++)
        begin
            rho_dly_reg[k] <= rho_dly_reg[k-1];
        end
        for (int k = 1; k < SD_KE; k++)
        begin
            ke_dly_reg[k] <= ke_dly_reg[k-1];
        end
        for (int k = 1; k < SD_OPS; k++)
        begin
            ops_dly_reg[k] <= ops_dly_reg[k-1];
        end
    end

    assign mu   = mu_reg;
    assign mv   = mv_reg;
    assign e    = e_reg;
    assign flux = flux_reg;

endmodule

// ===== rtl/core/eff2d_central.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eff2d_central
// Central flux of the averaged state and conserved differences.
// Primitives at T0, momenta at T1, energies at T35; results at T73.
// ----------------------------------------------------------------------------
module eff2d_central
    import eff2d_pkg::*;
(
    input  logic               clk,
    input  logic        [30:0] rho_l,
    input  logic        [30:0] rho_r,
    input  logic        [30:0] p_l,
    input  logic        [30:0] p_r,
    input  logic signed [31:0] fx,
    input  logic signed [31:0] fy,
    input  logic signed [31:0] mu_l,
    input  logic signed [31:0] mu_r,
    input  logic signed [31:0] mv_l,
    input  logic signed [31:0] mv_r,
    input  logic signed [31:0] e_l,
    input  logic signed [31:0] e_r,
    output cons4_t             avg,
    output cons4_t             cdf
);

    typedef struct packed {
        logic signed [31:0] rhoa;
        logic signed [31:0] rhoua;
        logic signed [31:0] rhova;
        logic signed [31:0] pa;
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] cdf_mass;
        logic signed [31:0] cdf_xmom;
        logic signed [31:0] cdf_ymom;
    } cen_ops_t;

    typedef struct packed {
        cons4_t avg;
        cons4_t cdf;
    } cen_res_t;

    logic signed [31:0] rhoa1_reg, pa1_reg, cdf0_1_reg, fx1_reg, fy1_reg;
    cen_ops_t           ops2_reg;
    cen_ops_t           ops_dly_reg [CD_OPS];
    cen_ops_t           ops4, ops36, ops38;
    logic signed [31:0] t1_reg, t2_reg, s_reg, vcont;
    logic signed [31:0] rhoea_reg, cdf3_36_reg, epa_reg, cdf3_37_reg;
    logic signed [31:0] epa38_reg, cdf3_38_reg;
    logic signed [31:0] a0_reg, b1_reg, c1_reg, b2_reg, c2_reg, a3_reg;
    cons4_t             cdf39_reg;
    cen_res_t           res_reg;
    cen_res_t           res_dly_reg [CD_RES];

    assign ops4  = ops_dly_reg[1];
    assign ops36 = ops_dly_reg[CD_OPS-3];
    assign ops38 = ops_dly_reg[CD_OPS-1];

    eff2d_div u_vdiv (
        .clk (clk),
        .num (s_reg),
        .den ({ops4.rhoa[31], ops4.rhoa}),
        .quo (vcont)
    );

    always_ff @(posedge clk)
    begin
        // T1
        rhoa1_reg  <= qavg({1'b0, rho_l}, {1'b0, rho_r});
        pa1_reg    <= qavg({1'b0, p_l}, {1'b0, p_r});
        cdf0_1_reg <= qsub({1'b0, rho_r}, {1'b0, rho_l});
        fx1_reg    <= fx;
        fy1_reg    <= fy;
        // T2
        ops2_reg.rhoa     <= rhoa1_reg;
        ops2_reg.rhoua    <= qavg(mu_l, mu_r);
        ops2_reg.rhova    <= qavg(mv_l, mv_r);
        ops2_reg.pa       <= pa1_reg;
        ops2_reg.fx       <= fx1_reg;
        ops2_reg.fy       <= fy1_reg;
        ops2_reg.cdf_mass <= cdf0_1_reg;
        ops2_reg.cdf_xmom <= qsub(mu_r, mu_l);
        ops2_reg.cdf_ymom <= qsub(mv_r, mv_l);
        // T3, T4
        t1_reg <= qmul(ops2_reg.rhoua, ops2_reg.fx);
        t2_reg <= qmul(ops2_reg.rhova, ops2_reg.fy);
        s_reg  <= qadd(t1_reg, t2_reg);
        // T36 .. T38
        rhoea_reg   <= qavg(e_l, e_r);
        cdf3_36_reg <= qsub(e_r, e_l);
        epa_reg     <= qadd(rhoea_reg, ops36.pa);
        cdf3_37_reg <= cdf3_36_reg;
        epa38_reg   <= epa_reg;
        cdf3_38_reg <= cdf3_37_reg;
        // T39
        a0_reg           <= qmul(vcont, ops38.rhoa);
        b1_reg           <= qmul(vcont, ops38.rhoua);
        c1_reg           <= qmul(ops38.pa, ops38.fx);
        b2_reg           <= qmul(vcont, ops38.rhova);
        c2_reg           <= qmul(ops38.pa, ops38.fy);
        a3_reg           <= qmul(vcont, epa38_reg);
        cdf39_reg.mass   <= ops38.cdf_mass;
        cdf39_reg.xmom   <= ops38.cdf_xmom;
        cdf39_reg.ymom   <= ops38.cdf_ymom;
        cdf39_reg.energy <= cdf3_38_reg;
        // T40
        res_reg.avg.mass   <= a0_reg;
        res_reg.avg.xmom   <= qadd(b1_reg, c1_reg);
        res_reg.avg.ymom   <= qadd(b2_reg, c2_reg);
        res_reg.avg.energy <= a3_reg;
        res_reg.cdf        <= cdf39_reg;
    end

    always_ff @(posedge clk)
    begin
        ops_dly_reg[0] <= ops2_reg;
        res_dly_reg[0] <= res_reg;
        for (int k = 1; k < CD_OPS; k++)
        begin
            ops_dly_reg[k] <= ops_dly_reg[k-1];
        end
        for (int k = 1; k < CD_RES; k++)
        begin
            res_dly_reg[k] <= res_dly_reg[k-1];
        end
    end

    assign avg = res_dly_reg[CD_RES-1].avg;
    assign cdf = res_dly_reg[CD_RES-1].cdf;

endmodule
